### hw/rtl/deque_with_indexed_read_defines.svh
// Assertion macros shared by the deque RTL.
// Expects clk and rst to be visible in the scope where a macro is used.
`ifndef DEQUE_WITH_INDEXED_READ_DEFINES_SVH
`define DEQUE_WITH_INDEXED_READ_DEFINES_SVH

// Same-cycle implication, muted during reset
`define DWIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted during reset
`define DWIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dwir_pkg.sv
// Shared types and constants for the deque with indexed read.
// No dependencies; imported by dwir_cell and deque_with_indexed_read.
package dwir_pkg;

  // Field widths
  localparam int MODE_W    = 3;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 9;
  localparam int CNT_W     = 9;
  localparam int STAT_W    = 2;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  // Default capacity and read gather group size
  localparam int DEPTH_DEF  = 256;
  localparam int GROUP_SIZE = 16;

  // Operation codes
  localparam logic [MODE_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [MODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] OP_READ_FRONT = 3'd4;
  localparam logic [MODE_W-1:0] OP_READ_BACK  = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic shift_up;    // take word from the cell nearer the front
    logic shift_down;  // take word from the cell nearer the back
    logic put_back;    // cell at index == count loads the pushed word
  } cell_cmd_t;

endpackage

### hw/rtl/deque_with_indexed_read.sv
// Deque with indexed read: a row of word cells with cell 0 at the front.
// An accepted beat steps through the IDLE, GATHER and FINISH phases; FINISH waits while m_tready is low.
// No new beat is taken until the previous result loads; the two-stage OR gather of the read word is not overlapped.
// The gather registers groups of cells, then merges the groups into the output register.
// Reset: synchronous; clears count, sequencer and output valid; cell words stay undefined.
// s_tready stays low while rst is high, so no beat is taken during reset.
`include "deque_with_indexed_read_defines.svh"

module deque_with_indexed_read #(
  parameter int DEPTH = dwir_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: [31:0] value, [40:32] position, [47:41] zero
  input  logic [dwir_pkg::S_TDATA_W-1:0]   s_tdata,
  // s_tuser: [2:0] mode
  input  logic [dwir_pkg::MODE_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: [31:0] read_value, [40:32] count, [47:41] zero
  output logic [dwir_pkg::M_TDATA_W-1:0]   m_tdata,
  // m_tuser: [1:0] status
  output logic [dwir_pkg::STAT_W-1:0]      m_tuser
);
  import dwir_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam int NG = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_GATHER = 2'd1;
  localparam logic [1:0] PH_FINISH = 2'd2;

  logic [1:0]          phase;
  logic [CW-1:0]       occ;
  logic [CW-1:0]       occ_next;
  logic                rd_en;
  logic                rd_en_next;
  logic [IW-1:0]       rd_target;
  logic [IW-1:0]       rd_target_next;
  logic [STAT_W-1:0]   st_hold;
  logic [STAT_W-1:0]   st_next;
  logic [CW-1:0]       cnt_hold;
  cell_cmd_t           cmd;
  logic                accept;
  logic                full;
  logic                empty;
  logic                miss;
  logic                load_out;
  logic                push_ok;
  logic [MODE_W-1:0]   mode;
  logic [WORD_W-1:0]   value;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       occ_ext;

  logic [WORD_W-1:0]   cell_word [DEPTH];
  logic [WORD_W-1:0]   cell_rd   [DEPTH];
  logic [WORD_W-1:0]   grp       [NG];
  logic [WORD_W-1:0]   grp_or    [NG];
  logic [WORD_W-1:0]   all_or;

  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [WORD_W-1:0]   out_value;
  logic [CNT_W-1:0]    out_count;

  // Input beat unpacking
  assign mode    = s_tuser;
  assign value   = s_tdata[WORD_W-1:0];
  assign pos_ext = PW'(s_tdata[WORD_W +: POS_W]);
  assign occ_ext = PW'(occ);

  assign s_tready = (phase == PH_IDLE) && !rst;
  assign accept   = s_tvalid && s_tready;
  assign full     = (occ == CW'(DEPTH));
  assign empty    = (occ == '0);
  assign miss     = (pos_ext == '0) || (pos_ext > occ_ext);
  assign push_ok  = accept && !full && (mode == OP_PUSH_BACK || mode == OP_PUSH_FRONT);

  // Result register loads once the previous beat has gone
  assign load_out = (phase == PH_FINISH) && (!out_valid || m_tready);

  // Operation decode: row command, new count, read address, status
  always_comb begin
    cmd            = '0;
    occ_next       = occ;
    rd_en_next     = 1'b0;
    rd_target_next = rd_target;
    st_next        = ST_DONE;
    if (accept) begin
      unique case (mode)
        OP_PUSH_BACK: begin
          if (full) begin
            st_next = ST_FULL;
          end else begin
            cmd.put_back = 1'b1;
            occ_next     = occ + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            st_next = ST_FULL;
          end else begin
            cmd.shift_up = 1'b1;
            occ_next     = occ + 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            st_next = ST_MISS;
          end else begin
            occ_next = occ - 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            st_next = ST_MISS;
          end else begin
            cmd.shift_down = 1'b1;
            occ_next       = occ - 1'b1;
          end
        end
        OP_READ_FRONT: begin
          if (miss) begin
            st_next = ST_MISS;
          end else begin
            rd_en_next     = 1'b1;
            rd_target_next = IW'(pos_ext - 1'b1);
          end
        end
        OP_READ_BACK: begin
          if (miss) begin
            st_next = ST_MISS;
          end else begin
            rd_en_next     = 1'b1;
            rd_target_next = IW'(occ_ext - pos_ext);
          end
        end
        default: begin
          st_next = ST_DONE;
        end
      endcase
    end
  end

  // Row of cells; cell 0 takes the pushed word on a front push
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] prev_w;
    logic [WORD_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = value;
    end else begin : g_mid
      assign prev_w = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_inner
      assign next_w = cell_word[i+1];
    end
    dwir_cell #(
      .DEPTH (DEPTH),
      .IDX   (i),
      .CW    (CW),
      .IW    (IW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (occ),
      .value     (value),
      .from_prev (prev_w),
      .from_next (next_w),
      .rd_en     (rd_en),
      .rd_target (rd_target),
      .word      (cell_word[i]),
      .rd_word   (cell_rd[i])
    );
  end

  // First gather level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < DEPTH) begin
          grp_or[g] = grp_or[g] | cell_rd[g * GROUP_SIZE + k];
        end
      end
    end
  end

  // Second gather level: OR across the group registers
  always_comb begin
    all_or = '0;
    for (int g = 0; g < NG; g++) begin
      all_or = all_or | grp[g];
    end
  end

  // Sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      occ       <= '0;
      rd_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (phase)
        PH_IDLE: begin
          if (accept) begin
            phase <= PH_GATHER;
            occ   <= occ_next;
            rd_en <= rd_en_next;
          end
        end
        PH_GATHER: begin
          phase <= PH_FINISH;
        end
        PH_FINISH: begin
          if (load_out) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // Payload registers along the result path
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_target <= rd_target_next;
      st_hold   <= st_next;
      cnt_hold  <= occ_next;
    end
    if (phase == PH_GATHER) begin
      grp <= grp_or;
    end
    if (load_out) begin
      out_status <= st_hold;
      out_value  <= all_or;
      out_count  <= CNT_W'(cnt_hold);
    end
  end

  // Output beat packing
  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = M_TDATA_W'({out_count, out_value});

  // Checks
  `DWIR_ASSERT_NOW(a_occ_bound, 1'b1, occ <= CW'(DEPTH), "occupancy above capacity")
  `DWIR_ASSERT_NXT(a_push_grows, push_ok, occ == $past(occ) + 1'b1, "push did not grow count")
  `DWIR_ASSERT_NXT(a_busy_holds, phase != PH_IDLE, $stable(occ), "count moved while busy")
  `DWIR_ASSERT_NOW(a_fail_zero, m_tvalid && (out_status != ST_DONE), out_value == '0, "failed beat carries a word")

endmodule

### hw/rtl/dwir_cell.sv
// One storage cell of the deque row: holds the word at one position from the front.
// Depends on dwir_pkg.
module dwir_cell #(
  parameter int DEPTH = 256,
  parameter int IDX   = 0,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  dwir_pkg::cell_cmd_t           cmd,
  input  logic [CW-1:0]                 count,
  input  logic [dwir_pkg::WORD_W-1:0]   value,
  input  logic [dwir_pkg::WORD_W-1:0]   from_prev,
  input  logic [dwir_pkg::WORD_W-1:0]   from_next,
  input  logic                          rd_en,
  input  logic [IW-1:0]                 rd_target,
  output logic [dwir_pkg::WORD_W-1:0]   word,
  output logic [dwir_pkg::WORD_W-1:0]   rd_word
);
  import dwir_pkg::*;

  // Word register: shift along the row or load a back push
  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      word <= from_prev;
    end else if (cmd.shift_down) begin
      word <= from_next;
    end else if (cmd.put_back && (count == CW'(IDX))) begin
      word <= value;
    end
  end

  // Gated read contribution; zero unless this cell is addressed
  assign rd_word = (rd_en && (rd_target == IW'(IDX))) ? word : '0;

endmodule
